// File: rtl/core/rgbhsl_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSL package
// Shared widths and types for the RGB to HSL pixel converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

	// Channel, sum and result widths.
	localparam int CH_W   = 8;
	localparam int SUM_W  = 9;
	localparam int DIFF_W = 9;
	localparam int HDEN_W = 11;
	localparam int OUT_W  = 16;

	// Top value of a lightness sum (255 + 255).
	localparam logic [SUM_W-1:0] SUM_MAX  = 9'd510;
	// Sums below this value divide saturation by the sum itself.
	localparam logic [SUM_W-1:0] SUM_HALF = 9'd255;

	// Channel that holds the maximum, checked red first, then green, then blue.
	typedef enum logic [1:0] {
		MAX_RED,
		MAX_GREEN,
		MAX_BLUE
	} max_sel_t;

endpackage

// File: rtl/core/rgb_to_hsl_converter_top.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Converts one 8-bit RGB pixel per clock, while no stall on hsl_ready fills
// the pipeline, into hue, saturation and the lightness sum (max + min). The
// design is a pipeline of 4 + (FRACTION_BITS + 2) / 2 register stages, and
// it takes a new pixel every cycle unless a stall has filled it. Three
// stages find the extremes, the differences and the dividends;
// the hue and saturation quotients come from two restoring dividers that run
// side by side and resolve two quotient bits per stage; the last stage rounds
// and holds the result. Each stage keeps its own valid bit and moves whenever
// the stage after it is empty or moving, so bubbles close up and a waiting
// result does not block new requests while the pipeline has room.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_top
	import rgbhsl_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	output logic                pixel_ready,
	input  logic [CH_W-1:0]     red,
	input  logic [CH_W-1:0]     green,
	input  logic [CH_W-1:0]     blue,
	output logic                hsl_valid,
	input  logic                hsl_ready,
	output logic [OUT_W-1:0]    hue,
	output logic [OUT_W-1:0]    saturation,
	output logic [SUM_W-1:0]    lightness_sum
);

	// Quotient bits carry one extra bit for round-half-up.
	localparam int QW   = FRACTION_BITS + 1;
	localparam int NDIV = (FRACTION_BITS + 2) / 2;
	localparam int P    = NDIV + 4;

	// Stage valid bits and per-stage load enables.
	logic         vld_s [P];
	logic         en    [P+1];

	// Stage 1: extremes.
	logic [CH_W-1:0] r_s1, g_s1, b_s1, mx_s1, mn_s1;
	max_sel_t        sel_s1;
	// Stage 2: delta, sum and channel difference.
	logic [CH_W-1:0]          delta_s2;
	logic [SUM_W-1:0]         sum_s2;
	logic signed [DIFF_W-1:0] diff_s2;
	max_sel_t                 sel_s2;
	// Divider stages; index 0 is loaded by stage 3.
	logic [HDEN_W-1:0] hrem_s  [NDIV+1];
	logic [HDEN_W-1:0] hden_s  [NDIV+1];
	logic [QW-1:0]     hq_s    [NDIV+1];
	logic [CH_W-1:0]   srem_s  [NDIV+1];
	logic [CH_W-1:0]   sden_s  [NDIV+1];
	logic [QW-1:0]     slow_s  [NDIV+1];
	logic              achro_s [NDIV+1];
	logic [SUM_W-1:0]  lsum_s  [NDIV+1];
	// Output stage.
	logic [OUT_W-1:0] hue_s4, sat_s4;
	logic [SUM_W-1:0] lsum_s4;

	// A stage loads when it is empty or its request moves on.
	always_comb begin
		en[P] = hsl_ready;
		for (int i = P - 1; i >= 0; i--) begin
			en[i] = !vld_s[i] || en[i+1];
		end
	end

	assign pixel_ready = en[0];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < P; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			if (en[0]) begin
				vld_s[0] <= pixel_valid;
			end
			for (int i = 1; i < P; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// Stage 1: find the maximum channel and the extremes.
	max_sel_t        sel_c;
	logic [CH_W-1:0] mx_c, mn_c;

	always_comb begin
		if (red >= green && red >= blue) begin
			sel_c = MAX_RED;
			mx_c  = red;
		end else if (green >= blue) begin
			sel_c = MAX_GREEN;
			mx_c  = green;
		end else begin
			sel_c = MAX_BLUE;
			mx_c  = blue;
		end
		mn_c = red;
		if (green < mn_c) mn_c = green;
		if (blue < mn_c) mn_c = blue;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			r_s1   <= red;
			g_s1   <= green;
			b_s1   <= blue;
			mx_s1  <= mx_c;
			mn_s1  <= mn_c;
			sel_s1 <= sel_c;
		end
	end

	// Stage 2: delta, sum and the signed channel difference for the hue.
	logic signed [DIFF_W-1:0] diff_c;

	always_comb begin
		unique case (sel_s1)
			MAX_RED:   diff_c = signed'({1'b0, g_s1}) - signed'({1'b0, b_s1});
			MAX_GREEN: diff_c = signed'({1'b0, b_s1}) - signed'({1'b0, r_s1});
			MAX_BLUE:  diff_c = signed'({1'b0, r_s1}) - signed'({1'b0, g_s1});
			default:   diff_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			delta_s2 <= mx_s1 - mn_s1;
			sum_s2   <= {1'b0, mx_s1} + {1'b0, mn_s1};
			diff_s2  <= diff_c;
			sel_s2   <= sel_s1;
		end
	end

	// Stage 3: hue numerator and divisor, saturation divisor and dividend.
	logic [HDEN_W-1:0]        six_c;
	logic signed [HDEN_W:0]   diffx_c;
	logic signed [HDEN_W:0]   n_c;
	logic [SUM_W-1:0]         sden_c;

	always_comb begin
		six_c   = {1'b0, delta_s2, 2'b00} + {2'b00, delta_s2, 1'b0};
		diffx_c = {{(HDEN_W + 1 - DIFF_W){diff_s2[DIFF_W-1]}}, diff_s2};
		unique case (sel_s2)
			MAX_RED: begin
				if (diff_s2 < 0) begin
					n_c = diffx_c + signed'({1'b0, six_c});
				end else begin
					n_c = diffx_c;
				end
			end
			MAX_GREEN: n_c = signed'({3'b000, delta_s2, 1'b0}) + diffx_c;
			MAX_BLUE:  n_c = signed'({2'b00, delta_s2, 2'b00}) + diffx_c;
			default:   n_c = '0;
		endcase
		if (sum_s2 < SUM_HALF) begin
			sden_c = sum_s2;
		end else begin
			sden_c = SUM_MAX - sum_s2;
		end
	end

	// The saturation dividend is delta * 2^QW - 2 * delta: its high part is
	// delta - 1 and its low QW bits are the two's complement of 2 * delta.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			hrem_s[0]  <= n_c[HDEN_W-1:0];
			hden_s[0]  <= six_c;
			hq_s[0]    <= '0;
			srem_s[0]  <= delta_s2 - CH_W'(1);
			sden_s[0]  <= sden_c[CH_W-1:0];
			slow_s[0]  <= QW'(0) - QW'({delta_s2, 1'b0});
			achro_s[0] <= (delta_s2 == '0);
			lsum_s[0]  <= sum_s2;
		end
	end

	// Divider stages: two restoring steps each for hue and saturation.
	for (genvar k = 1; k <= NDIV; k++) begin : g_div
		logic [HDEN_W-1:0] hr, hrn;
		logic [QW-1:0]     hq, hqn;
		logic [CH_W-1:0]   sr, srn;
		logic [QW-1:0]     sl, sln;

		always_comb begin
			logic [HDEN_W:0] ht;
			logic [CH_W:0]   st;
			hr = hrem_s[k-1];
			hq = hq_s[k-1];
			sr = srem_s[k-1];
			sl = slow_s[k-1];
			for (int j = 0; j < 2; j++) begin
				if (2 * (k - 1) + j < QW) begin
					ht = {hr, 1'b0};
					if (ht >= {1'b0, hden_s[k-1]}) begin
						ht = ht - {1'b0, hden_s[k-1]};
						hq = {hq[QW-2:0], 1'b1};
					end else begin
						hq = {hq[QW-2:0], 1'b0};
					end
					hr = ht[HDEN_W-1:0];
					st = {sr, sl[QW-1]};
					if (st >= {1'b0, sden_s[k-1]}) begin
						st = st - {1'b0, sden_s[k-1]};
						sl = {sl[QW-2:0], 1'b1};
					end else begin
						sl = {sl[QW-2:0], 1'b0};
					end
					sr = st[CH_W-1:0];
				end
			end
			hrn = hr;
			hqn = hq;
			srn = sr;
			sln = sl;
		end

		always_ff @(posedge clk) begin
			if (en[2+k]) begin
				hrem_s[k]  <= hrn;
				hden_s[k]  <= hden_s[k-1];
				hq_s[k]    <= hqn;
				srem_s[k]  <= srn;
				sden_s[k]  <= sden_s[k-1];
				slow_s[k]  <= sln;
				achro_s[k] <= achro_s[k-1];
				lsum_s[k]  <= lsum_s[k-1];
			end
		end
	end

	// Output stage: round half up, wrap the hue to a turn, clear gray pixels.
	logic [QW:0]                    hround_c, sround_c;
	logic [FRACTION_BITS+OUT_W-1:0] hext_c, sext_c;

	always_comb begin
		hround_c = {1'b0, hq_s[NDIV]} + (QW + 1)'(1);
		sround_c = {1'b0, slow_s[NDIV]} + (QW + 1)'(1);
		if (achro_s[NDIV]) begin
			hext_c = '0;
			sext_c = '0;
		end else begin
			hext_c = {{OUT_W{1'b0}}, hround_c[FRACTION_BITS:1]};
			sext_c = {{OUT_W{1'b0}}, sround_c[FRACTION_BITS:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en[P-1]) begin
			hue_s4  <= hext_c[OUT_W-1:0];
			sat_s4  <= sext_c[OUT_W-1:0];
			lsum_s4 <= lsum_s[NDIV];
		end
	end

	assign hsl_valid     = vld_s[P-1];
	assign hue           = hue_s4;
	assign saturation    = sat_s4;
	assign lightness_sum = lsum_s4;

endmodule

// File: rtl/core/rgbhsl_checker.sv
// ----------------------------------------------------------------------------
// RGB to HSL port checker
// Watches the converter's ports and flags results or handshakes that cannot
// come from a correct conversion.
// ----------------------------------------------------------------------------
module rgbhsl_checker
	import rgbhsl_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             pixel_valid,
	input logic             pixel_ready,
	input logic [CH_W-1:0]  red,
	input logic [CH_W-1:0]  green,
	input logic [CH_W-1:0]  blue,
	input logic             hsl_valid,
	input logic             hsl_ready,
	input logic [OUT_W-1:0] hue,
	input logic [OUT_W-1:0] saturation,
	input logic [SUM_W-1:0] lightness_sum
);

	// A waiting request keeps its pixel until it is taken.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_ready |=> pixel_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("Waiting request changed.");

	// A stalled result keeps its values.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && !hsl_ready |=> hsl_valid && $stable(hue) && $stable(saturation)
			&& $stable(lightness_sum))
		else $error("Stalled result changed.");

	// With no result waiting, the pipeline always has room for a request.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!hsl_valid |-> pixel_ready)
		else $error("Request refused while the output stage is empty.");

	// Black and white pixels are gray: no hue and no saturation.
	a_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && (lightness_sum == '0 || lightness_sum == SUM_MAX)
			|-> saturation == '0 && hue == '0)
		else $error("Black or white pixel with color.");

	// Zero saturation only comes from a gray pixel, which has hue zero.
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && saturation == '0 |-> hue == '0 && lightness_sum <= SUM_MAX)
		else $error("Gray result with nonzero hue or sum out of range.");

endmodule

bind rgb_to_hsl_converter_top rgbhsl_checker u_rgbhsl_checker (.*);
